// ===== design/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

  // request action codes
  typedef enum logic [1:0] {
    ACT_PREPEND = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_DUMP    = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  localparam int unsigned ValueW = 32;

endpackage

`default_nettype wire

// ===== design/ordered_list_engine_top.sv =====
`default_nettype none

// Bounded ordered list of signed 32-bit values, held as a ring in one
// synchronous RAM with a head pointer and an entry count. A request is taken
// when start is high and busy is low. Prepend and append give their single
// result in the next cycle and busy stays low, so a new request may follow
// at once. Remove and dump walk the RAM from the head through its single
// read port, one entry per cycle, and hold busy while they walk (remove
// reads, compares and moves each trailing entry one slot forward in the same
// pass; dump emits one result per entry). A remove or dump of an empty list
// answers in the next cycle without going busy. Every result is shown for
// exactly one cycle, marked by done_o, and must be taken then: the receiver
// cannot stall the block. The RAM needs no clearing after reset.
module ordered_list_engine_top
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     action_i,
  input  wire logic signed [ValueW-1:0]       value_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [ValueW-1:0]            item_value_o,
  output logic                                last_o,
  output logic [$clog2(CAPACITY+1)-1:0]       occupancy_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [CntW:0]   CapSum = (CntW + 1)'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_DUMP
  } state_e;

  // ring position from head plus offset, offset below capacity
  function automatic logic [IdxW-1:0] wrap(input logic [CntW:0] s);
    logic [CntW:0] t;
    t = (s >= CapSum) ? s - CapSum : s;
    return t[IdxW-1:0];
  endfunction

  state_e                   state_q;
  logic [CntW-1:0]          cnt_q;
  logic [IdxW-1:0]          head_q;
  logic [CntW-1:0]          rd_off_q;
  logic [CntW-1:0]          dv_off_q;
  logic                     dv_q;
  logic                     found_q;
  logic [ValueW-1:0]        val_q;
  logic                     done_q;
  status_e                  status_q;
  logic [ValueW-1:0]        item_q;
  logic                     last_q;
  logic [CntW-1:0]          occ_q;

  logic [ValueW-1:0]        mem_q [CAPACITY];
  logic [ValueW-1:0]        rdata_q;

  action_e                  act;
  logic                     accept;
  logic                     full;
  logic [IdxW-1:0]          head_dec;
  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;
  logic                     we;
  logic [IdxW-1:0]          wa;
  logic [ValueW-1:0]        wd;
  logic                     match;
  logic                     walk_done;

  assign act      = action_e'(action_i);
  assign accept   = start && (state_q == ST_IDLE);
  assign full     = (cnt_q == CapCnt);
  assign head_dec = (head_q == '0) ? IdxW'(CAPACITY - 1) : head_q - IdxW'(1);

  // read walk from the head, one offset per cycle
  assign rd_en   = (state_q != ST_IDLE) && (rd_off_q < cnt_q);
  assign rd_addr = wrap((CntW + 1)'(head_q) + (CntW + 1)'(rd_off_q));

  assign match     = dv_q && !found_q && (rdata_q == val_q);
  assign walk_done = !dv_q && (rd_off_q == cnt_q);

  // write port: inserts from idle, trailing moves during remove
  always_comb begin
    we = 1'b0;
    wa = wrap((CntW + 1)'(head_q) + (CntW + 1)'(cnt_q));
    wd = value_i;
    if (accept && !full && (act == ACT_PREPEND || act == ACT_APPEND)) begin
      we = 1'b1;
      if (act == ACT_PREPEND) begin
        wa = head_dec;
      end
    end else if (state_q == ST_REMOVE && dv_q && found_q) begin
      we = 1'b1;
      wa = wrap((CntW + 1)'(head_q) + (CntW + 1)'(dv_off_q) - (CntW + 1)'(1));
      wd = rdata_q;
    end
  end

  // entry ram
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      head_q   <= '0;
      rd_off_q <= '0;
      dv_off_q <= '0;
      dv_q     <= 1'b0;
      found_q  <= 1'b0;
      val_q    <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
      item_q   <= '0;
      last_q   <= 1'b0;
      occ_q    <= '0;
    end else begin
      done_q <= 1'b0;
      item_q <= '0;
      last_q <= 1'b1;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            unique case (act)
              ACT_PREPEND, ACT_APPEND: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= STAT_FULL;
                  occ_q    <= cnt_q;
                end else begin
                  status_q <= STAT_OK;
                  occ_q    <= cnt_q + CntW'(1);
                  cnt_q    <= cnt_q + CntW'(1);
                  if (act == ACT_PREPEND) begin
                    head_q <= head_dec;
                  end
                end
              end
              ACT_REMOVE: begin
                if (cnt_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= STAT_NOT_FOUND;
                  occ_q    <= cnt_q;
                end else begin
                  state_q  <= ST_REMOVE;
                  rd_off_q <= '0;
                  dv_q     <= 1'b0;
                  found_q  <= 1'b0;
                  val_q    <= value_i;
                end
              end
              ACT_DUMP: begin
                if (cnt_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= STAT_EMPTY;
                  occ_q    <= cnt_q;
                end else begin
                  state_q  <= ST_DUMP;
                  rd_off_q <= '0;
                  dv_q     <= 1'b0;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_REMOVE: begin
          dv_q     <= rd_en;
          dv_off_q <= rd_off_q;
          if (rd_en) begin
            rd_off_q <= rd_off_q + CntW'(1);
          end
          if (match) begin
            found_q <= 1'b1;
          end
          if (walk_done) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            if (found_q) begin
              status_q <= STAT_OK;
              cnt_q    <= cnt_q - CntW'(1);
              occ_q    <= cnt_q - CntW'(1);
            end else begin
              status_q <= STAT_NOT_FOUND;
              occ_q    <= cnt_q;
            end
          end
        end
        ST_DUMP: begin
          dv_q     <= rd_en;
          dv_off_q <= rd_off_q;
          if (rd_en) begin
            rd_off_q <= rd_off_q + CntW'(1);
          end
          // one result per entry read back
          if (dv_q) begin
            done_q   <= 1'b1;
            status_q <= STAT_OK;
            item_q   <= rdata_q;
            last_q   <= (dv_off_q == cnt_q - CntW'(1));
            occ_q    <= cnt_q;
          end
          if (walk_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign item_value_o = item_q;
  assign last_o       = last_q;
  assign occupancy_o  = occ_q;

endmodule

`default_nettype wire

// ===== test/ole_list_checker.sv =====
`timescale 1ns / 1ps

// watches the request and result channels of the list engine, keeps its own
// copy of the list and compares every result with the oldest one predicted
module ole_list_checker
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned OccW     = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [1:0]               action_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic                     done_i,
  input  wire logic [1:0]               status_i,
  input  wire logic signed [ValueW-1:0] item_value_i,
  input  wire logic                     last_i,
  input  wire logic [OccW-1:0]          occupancy_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned PrintCap = 60;

  typedef struct packed {
    status_e                    status;
    logic signed [ValueW-1:0]   item_value;
    logic                       last;
    logic [OccW-1:0]            occupancy;
  } list_result_t;

  // entries front to back, and results still owed by the block
  logic signed [ValueW-1:0] held_values[$];
  list_result_t             expected_results[$];
  int                       mismatch_count = 0;

  task automatic report_mismatch(input string what);
    begin
      if (mismatch_count < PrintCap) begin
        $display("%0t ns list check: %s", $time, what);
      end
      mismatch_count++;
    end
  endtask

  task automatic push_expected(input status_e st, input logic signed [ValueW-1:0] item,
                               input logic is_last);
    list_result_t res;
    begin
      res.status     = st;
      res.item_value = item;
      res.last       = is_last;
      res.occupancy  = OccW'(held_values.size());
      expected_results.push_back(res);
    end
  endtask

  // apply one request to the list copy and queue the results it causes
  task automatic predict_request(input action_e act, input logic signed [ValueW-1:0] val);
    int hit;
    int n;
    begin
      hit = -1;
      n   = held_values.size();
      case (act)
        ACT_PREPEND, ACT_APPEND: begin
          if (n >= CAPACITY) begin
            push_expected(STAT_FULL, '0, 1'b1);
          end else begin
            if (act == ACT_PREPEND) begin
              held_values.push_front(val);
            end else begin
              held_values.push_back(val);
            end
            push_expected(STAT_OK, '0, 1'b1);
          end
        end
        ACT_REMOVE: begin
          // only the frontmost match goes
          for (int i = 0; i < n; i++) begin
            if (hit < 0 && held_values[i] == val) hit = i;
          end
          if (hit < 0) begin
            push_expected(STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            held_values.delete(hit);
            push_expected(STAT_OK, '0, 1'b1);
          end
        end
        default: begin
          if (n == 0) begin
            push_expected(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              push_expected(STAT_OK, held_values[i], (i == n - 1));
            end
          end
        end
      endcase
    end
  endtask

  // compare one result with the oldest expectation
  task automatic check_result();
    list_result_t want;
    begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d value %0d",
                                  status_i, item_value_i));
      end else begin
        want = expected_results.pop_front();
        if (status_i !== want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
        end
        if (item_value_i !== want.item_value) begin
          report_mismatch($sformatf("item_value %0d, want %0d", item_value_i,
                                    want.item_value));
        end
        if (last_i !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", last_i, want.last));
        end
        if (occupancy_i !== want.occupancy) begin
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy_i,
                                    want.occupancy));
        end
      end
    end
  endtask

  // results of earlier requests first, then the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_values.delete();
      expected_results.delete();
    end else begin
      if ($isunknown(done_i)) begin
        report_mismatch("done_o unknown");
      end else if (done_i) begin
        check_result();
      end
      if (start_i && !busy_i) begin
        predict_request(action_e'(action_i), value_i);
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= mismatch_count;
  end

endmodule

// ===== test/tb_ordered_list_engine_top.sv =====
`timescale 1ns / 1ps

module tb_ordered_list_engine_top;
  import ole_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned OccW        = $clog2(CAPACITY + 1);
  localparam int unsigned RandomItems = 200;
  localparam int unsigned PhaseLen    = 30;
  localparam int unsigned DrainCycles = CAPACITY + 4;
  localparam int unsigned IdleLimit   = 400;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;
  typedef enum int {GAP_WIDE, GAP_NONE, GAP_NARROW} gap_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               action_i;
  logic signed [ValueW-1:0] value_i;
  logic                     done_o;
  logic [1:0]               status_o;
  logic signed [ValueW-1:0] item_value_o;
  logic                     last_o;
  logic [OccW-1:0]          occupancy_o;

  int   mismatch_total;
  int   results_outstanding;
  gap_e gap_mode = GAP_WIDE;

  // values inserted lately, so removes mostly find a match
  logic signed [ValueW-1:0] sent_values[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ordered_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .item_value_o(item_value_o),
    .last_o      (last_o),
    .occupancy_o (occupancy_o)
  );

  ole_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_list_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .action_i    (action_i),
    .value_i     (value_i),
    .done_i      (done_o),
    .status_i    (status_o),
    .item_value_i(item_value_o),
    .last_i      (last_o),
    .occupancy_i (occupancy_o),
    .fail_count_o(mismatch_total),
    .pending_o   (results_outstanding)
  );

  // small set of values with extremes and duplicates
  function automatic logic signed [ValueW-1:0] pool_value(input int unsigned idx);
    case (idx)
      0: return 32'sh0000_0000;
      1: return 32'sh0000_0001;
      2: return -32'sd1;
      3: return 32'sh7FFF_FFFF;
      4: return 32'sh8000_0000;
      5: return 32'sh5555_5555;
      6: return 32'shAAAA_AAAA;
      default: return 32'sd5;
    endcase
  endfunction

  // wait out the sender gap, then hold the request until busy is low
  task automatic issue_request(input action_e act, input logic signed [ValueW-1:0] val);
    int unsigned gap;
    begin
      case (gap_mode)
        GAP_NONE:   gap = 0;
        GAP_NARROW: gap = $urandom_range(0, 2);
        default:    gap = $urandom_range(0, 9);
      endcase
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      start    <= 1'b1;
      action_i <= act;
      value_i  <= val;
      if (act == ACT_PREPEND || act == ACT_APPEND) begin
        sent_values.push_back(val);
        if (sent_values.size() > 32) void'(sent_values.pop_front());
      end
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
    end
  endtask

  // no request or result for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_ordered_list_engine_top: errors");
    $finish;
  end

  initial begin : stimulus
    mix_e                     mix;
    action_e                  act;
    logic signed [ValueW-1:0] val;
    int unsigned              r;
    rst_ni   = 1'b0;
    start    = 1'b0;
    action_i = ACT_PREPEND;
    value_i  = '0;
    mix      = MIX_EVEN;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: dump and a remove that cannot match
    issue_request(ACT_DUMP, 32'sh1234_5678);
    issue_request(ACT_REMOVE, 32'sh0000_0000);
    // extremes at both ends
    issue_request(ACT_APPEND, 32'sh7FFF_FFFF);
    issue_request(ACT_PREPEND, 32'sh8000_0000);
    issue_request(ACT_APPEND, 32'sh0000_0000);
    issue_request(ACT_APPEND, -32'sd1);
    issue_request(ACT_PREPEND, 32'sh0000_0001);
    issue_request(ACT_DUMP, -32'sd1);
    // miss, front, back, then a duplicate where the front copy goes
    issue_request(ACT_REMOVE, 32'sd42);
    issue_request(ACT_REMOVE, 32'sh0000_0001);
    issue_request(ACT_REMOVE, -32'sd1);
    issue_request(ACT_APPEND, 32'sh0000_0000);
    issue_request(ACT_REMOVE, 32'sh0000_0000);
    // fill up, bounce off a full list, dump it all, take one from the middle
    for (int k = 0; k < 13; k++) begin
      val = ((k % 2) != 0) ? 32'shAAAA_AAAA : 32'sh5555_5555;
      issue_request(((k % 2) != 0) ? ACT_APPEND : ACT_PREPEND, val ^ k);
    end
    issue_request(ACT_PREPEND, 32'sd7);
    issue_request(ACT_APPEND, 32'sd8);
    issue_request(ACT_DUMP, 32'sd0);
    issue_request(ACT_REMOVE, 32'sh7FFF_FFFF);

    // random requests in phases that drift the list toward full or empty or hold it even
    for (int n = 0; n < RandomItems; n++) begin
      if ((n % PhaseLen) == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        gap_mode = gap_e'($urandom_range(0, 2));
      end
      r = $urandom_range(0, 9);
      case (mix)
        MIX_GROW: begin
          act = (r < 4) ? ACT_PREPEND : (r < 8) ? ACT_APPEND : (r < 9) ? ACT_REMOVE : ACT_DUMP;
        end
        MIX_SHRINK: begin
          act = (r < 1) ? ACT_PREPEND : (r < 2) ? ACT_APPEND : (r < 8) ? ACT_REMOVE : ACT_DUMP;
        end
        default: begin
          act = action_e'(r % 4);
        end
      endcase
      r = $urandom_range(0, 9);
      if (act == ACT_REMOVE && r < 7 && sent_values.size() != 0) begin
        val = sent_values[$urandom_range(0, sent_values.size() - 1)];
      end else if (act != ACT_DUMP && r < 8) begin
        val = pool_value($urandom_range(0, 7));
      end else begin
        val = $urandom;
      end
      issue_request(act, val);
    end
    start <= 1'b0;

    // let every owed result arrive, then watch for strays
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("tb_ordered_list_engine_top: clean");
    end else begin
      $display("tb_ordered_list_engine_top: errors");
    end
    $finish;
  end

endmodule

// ===== ordered_list_engine_top.f =====
design/ole_pkg.sv
design/ordered_list_engine_top.sv
test/ole_list_checker.sv
test/tb_ordered_list_engine_top.sv
